// ===== rtl/core/bcp_pkg.sv =====
// Shared types, constants and helpers for the bracketed command parser.
// No dependencies; imported by bcp_token_match and bracketed_command_parser.
`default_nettype none

package bcp_pkg;

    // Parser phase within one message buffer
    typedef enum logic [2:0] {
        PH_SEEK  = 3'd0,
        PH_SKIP1 = 3'd1,
        PH_TOK1  = 3'd2,
        PH_SKIP2 = 3'd3,
        PH_TOK2  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    // Command codes
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_STOP    = 2'd1;
    localparam logic [1:0] CMD_VIBRATE = 2'd2;
    localparam logic [1:0] CMD_ERR     = 2'd3;

    localparam int MAX_LEN_DEFAULT = 32;

    localparam int          NUM_KW    = 3;
    localparam logic [2:0]  TOK_SAT   = 3'd7;
    localparam logic [7:0]  CH_OPEN   = 8'h3C;
    localparam logic [7:0]  CH_CLOSE  = 8'h3E;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_NUL    = 8'h00;

    // Keyword text, one row per keyword, padded with zero bytes
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{8'h53, 8'h54, 8'h41, 8'h52, 8'h54, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h54, 8'h4F, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h56, 8'h49, 8'h42, 8'h52, 8'h41, 8'h54, 8'h45, 8'h00}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd5, 3'd4, 3'd7};

    // Keyword matching state carried between the top level and the matcher
    typedef struct packed {
        logic [2:0] index;
        logic [2:0] alive;
        logic [1:0] hit;
    } kw_state_t;

    localparam kw_state_t KW_RESET = '{index: 3'd0, alive: 3'b111, hit: CMD_ERR};

    // Uppercase hex digit to nibble; anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
            end
            hex_nibble = d[3:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bcp_token_match.sv =====
// Prefix matcher for the first token against the three keywords.
// Depends on bcp_pkg for the keyword table and kw_state_t.
`default_nettype none

module bcp_token_match (
    input  wire logic [7:0]        char_in,
    input  bcp_pkg::kw_state_t     cur,
    output bcp_pkg::kw_state_t     nxt
);
    import bcp_pkg::*;

    // Check one character against every keyword still alive
    always_comb begin
        kw_state_t s;
        s = cur;
        if (cur.index < TOK_SAT) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (s.alive[k] && cur.index < KW_LEN[k]) begin
                    if (char_in != KW_TEXT[k][cur.index]) begin
                        s.alive[k] = 1'b0;
                    end else if (cur.index == KW_LEN[k] - 3'd1 && s.hit == CMD_ERR) begin
                        s.hit = 2'(k);
                    end
                end
            end
            s.index = cur.index + 3'd1;
        end
        nxt = s;
    end

endmodule

`default_nettype wire

// ===== rtl/core/bracketed_command_parser.sv =====
// Top level of the bracketed command parser: byte-stream state, result register.
// Depends on bcp_pkg and bcp_token_match.
`default_nettype none

// The parser takes one byte per cycle on the s_ channel and gives one result on
// the m_ channel for each byte marked with s_last: the command code (0 start,
// 1 stop, 2 vibrate, 3 error) and the 16-bit hex value, zero for errors. Every
// byte is folded into the parse state in the cycle it is accepted, and the
// result of a last byte is formed in that same cycle and lands in the output
// register in the following cycle. A new byte is taken every cycle; input stalls only
// while a result sits in the output register and m_ready is low. MAX_LEN bounds
// the distance from the '<' to the last '>' (offset must stay below it).
module bracketed_command_parser #(
    parameter int MAX_LEN = bcp_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_in,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_command,
    output logic [15:0]      m_value
);
    import bcp_pkg::*;

    localparam logic [8:0] MaxLenW = 9'(MAX_LEN);

    phase_t      phase_reg, phase_next;
    kw_state_t   kw_reg, kw_next, kw_step;
    logic [2:0]  digit_count_reg, digit_count_next;
    logic [15:0] value_acc_reg, value_acc_next;
    logic [7:0]  offset_reg, offset_next;
    logic [7:0]  close_reg, close_next;
    logic        ended_reg, ended_next;

    logic        m_valid_reg;
    logic [1:0]  m_command_reg, m_command_next;
    logic [15:0] m_value_reg, m_value_next;

    logic        s_fire;
    logic        active;
    logic        is_space;
    logic        is_close;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign is_space = (s_char_in == CH_SPACE);
    assign is_close = (s_char_in == CH_CLOSE);
    // Token parsing runs only inside the text and before a zero byte
    assign active   = (phase_reg != PH_SEEK) && !ended_reg && (s_char_in != CH_NUL);

    bcp_token_match u_match (
        .char_in (s_char_in),
        .cur     (kw_reg),
        .nxt     (kw_step)
    );

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SEEK:  if (s_char_in == CH_OPEN) phase_next = PH_SKIP1;
            PH_SKIP1: if (active && !is_space) phase_next = PH_TOK1;
            PH_TOK1:  if (active && is_space) phase_next = PH_SKIP2;
            PH_SKIP2: if (active && !is_space && !is_close) phase_next = PH_TOK2;
            PH_TOK2:  if (active && (is_space || is_close)) phase_next = PH_DONE;
            PH_DONE:  phase_next = PH_DONE;
            default:  phase_next = PH_SEEK;
        endcase
    end

    // Datapath updates for one byte
    always_comb begin
        logic take_kw;
        logic take_digit;
        take_kw    = active && ((phase_reg == PH_SKIP1 && !is_space) ||
                                (phase_reg == PH_TOK1 && !is_space));
        take_digit = active && ((phase_reg == PH_SKIP2 && !is_space && !is_close) ||
                                (phase_reg == PH_TOK2 && !is_space && !is_close));

        kw_next          = take_kw ? kw_step : kw_reg;
        digit_count_next = digit_count_reg;
        value_acc_next   = value_acc_reg;
        if (take_digit && digit_count_reg < 3'd4) begin
            value_acc_next   = {value_acc_reg[11:0], hex_nibble(s_char_in)};
            digit_count_next = digit_count_reg + 3'd1;
        end

        offset_next = offset_reg;
        close_next  = close_reg;
        ended_next  = ended_reg;
        if (phase_reg == PH_SEEK) begin
            if (s_char_in == CH_OPEN) offset_next = 8'd0;
        end else begin
            if (offset_reg != 8'hFF) offset_next = offset_reg + 8'd1;
            if (is_close) close_next = offset_next;
            if (s_char_in == CH_NUL) ended_next = 1'b1;
        end
    end

    // Result for the last byte, from the updated state
    always_comb begin
        m_command_next = CMD_ERR;
        m_value_next   = 16'd0;
        if (phase_next != PH_SEEK && close_next != 8'd0 &&
            {1'b0, close_next} < MaxLenW && kw_next.hit != CMD_ERR) begin
            m_command_next = kw_next.hit;
            case (digit_count_next)
                3'd1:    m_value_next = {value_acc_next[3:0], 12'd0};
                3'd2:    m_value_next = {value_acc_next[7:0], 8'd0};
                3'd3:    m_value_next = {value_acc_next[11:0], 4'd0};
                3'd4:    m_value_next = value_acc_next;
                default: m_value_next = 16'd0;
            endcase
        end
    end

    // Advance parse state; clear it after each last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_SEEK;
            kw_reg          <= KW_RESET;
            digit_count_reg <= 3'd0;
            value_acc_reg   <= 16'd0;
            offset_reg      <= 8'd0;
            close_reg       <= 8'd0;
            ended_reg       <= 1'b0;
        end else if (s_fire) begin
            if (s_last) begin
                phase_reg       <= PH_SEEK;
                kw_reg          <= KW_RESET;
                digit_count_reg <= 3'd0;
                value_acc_reg   <= 16'd0;
                offset_reg      <= 8'd0;
                close_reg       <= 8'd0;
                ended_reg       <= 1'b0;
            end else begin
                phase_reg       <= phase_next;
                kw_reg          <= kw_next;
                digit_count_reg <= digit_count_next;
                value_acc_reg   <= value_acc_next;
                offset_reg      <= offset_next;
                close_reg       <= close_next;
                ended_reg       <= ended_next;
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && s_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_last) begin
            m_command_reg <= m_command_next;
            m_value_reg   <= m_value_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_command = m_command_reg;
    assign m_value   = m_value_reg;

    // Error results never carry a value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_command_reg == CMD_ERR |-> m_value_reg == 16'd0)
        else $error("error result with nonzero value");

    // A last byte returns the parser to seeking
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_last |=> phase_reg == PH_SEEK && kw_reg == KW_RESET)
        else $error("parse state not cleared after last byte");

    // Digit counter never passes four
    a_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        digit_count_reg <= 3'd4)
        else $error("digit count overflow");

    // A matched keyword stays alive and implies the first token was reached
    a_hit_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        kw_reg.hit != CMD_ERR |-> kw_reg.alive[kw_reg.hit] &&
                                  phase_reg != PH_SEEK && phase_reg != PH_SKIP1)
        else $error("keyword hit inconsistent with match state");

endmodule

`default_nettype wire
